// ===== hw/rtl/otr_pkg.sv =====
package otr_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_RESET_LOW  = 3'd0;
	localparam logic [2:0] REG_RESET_WAIT = 3'd1;
	localparam logic [2:0] REG_SLOT       = 3'd2;
	localparam logic [2:0] REG_READ_LOW   = 3'd3;
	localparam logic [2:0] REG_POLL_LIMIT = 3'd4;

	// register reset values
	localparam logic [15:0] RESET_LOW_DEFAULT  = 16'd60;
	localparam logic [15:0] RESET_WAIT_DEFAULT = 16'd50;
	localparam logic [15:0] SLOT_DEFAULT       = 16'd7;
	localparam logic [15:0] READ_LOW_DEFAULT   = 16'd1;
	localparam logic [15:0] POLL_LIMIT_DEFAULT = 16'd500;

	// bus command bytes
	localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
	localparam logic [7:0] CMD_CONVERT      = 8'h44;
	localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

	typedef struct packed {
		logic [15:0] reset_low_ticks;
		logic [15:0] reset_wait_ticks;
		logic [15:0] slot_ticks;
		logic [15:0] read_low_ticks;
		logic [15:0] poll_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] temp_high_byte;
		logic [7:0] temp_low_byte;
		logic       done_res;
		logic       busy_res;
		logic       line_release;
	} result_t;

endpackage

// ===== hw/rtl/otr_cfg_regs.sv =====
module otr_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [15:0]       wr_data,
	output otr_pkg::cfg_t     cfg
);

	otr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks  <= otr_pkg::RESET_LOW_DEFAULT;
			cfg_q.reset_wait_ticks <= otr_pkg::RESET_WAIT_DEFAULT;
			cfg_q.slot_ticks       <= otr_pkg::SLOT_DEFAULT;
			cfg_q.read_low_ticks   <= otr_pkg::READ_LOW_DEFAULT;
			cfg_q.poll_limit       <= otr_pkg::POLL_LIMIT_DEFAULT;
		end else if (wr_en) begin
			unique case (wr_index)
				otr_pkg::REG_RESET_LOW:  cfg_q.reset_low_ticks  <= wr_data;
				otr_pkg::REG_RESET_WAIT: cfg_q.reset_wait_ticks <= wr_data;
				otr_pkg::REG_SLOT:       cfg_q.slot_ticks       <= wr_data;
				otr_pkg::REG_READ_LOW:   cfg_q.read_low_ticks   <= wr_data;
				otr_pkg::REG_POLL_LIMIT: cfg_q.poll_limit       <= wr_data;
				default: ; // writes beyond the register list are dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/otr_seq.sv =====
module otr_seq #(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             start_request,
	input  logic             line_level,
	input  otr_pkg::cfg_t    cfg,
	output otr_pkg::result_t res
);

	localparam int TW = TICK_COUNT_WIDTH;
	localparam int CW = ((TW > 16) ? TW : 16) + 1;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_WR_LOW   = 4'd3,
		PH_WR_BIT   = 4'd4,
		PH_POLL     = 4'd5,
		PH_RD_LOW   = 4'd6,
		PH_RD_BIT   = 4'd7,
		PH_DONE     = 4'd8
	} phase_t;

	// sequence steps
	localparam logic [3:0] ST_RESET1   = 4'd0;
	localparam logic [3:0] ST_SKIP1    = 4'd1;
	localparam logic [3:0] ST_CONVERT  = 4'd2;
	localparam logic [3:0] ST_POLL     = 4'd3;
	localparam logic [3:0] ST_RESET2   = 4'd4;
	localparam logic [3:0] ST_SKIP2    = 4'd5;
	localparam logic [3:0] ST_READ_CMD = 4'd6;
	localparam logic [3:0] ST_READ_LO  = 4'd7;
	localparam logic [3:0] ST_READ_HI  = 4'd8;

	phase_t        phase_q, phase_d;
	logic [TW-1:0] tick_q, tick_d, tick_inc;
	logic [2:0]    bit_q, bit_d;
	logic [3:0]    step_q, step_d, step_go;
	logic [7:0]    shift_q, shift_d, shift_rd;
	logic [7:0]    low_q, low_d, high_q, high_d;
	logic          go;
	logic          tick_at_max;

	// timed phase is over on this tick
	function automatic logic timed_over(input logic [TW-1:0] t, input logic [15:0] lim);
		logic [CW-1:0] t_next;
		logic [CW-1:0] lim_ext;
		t_next  = {{(CW-TW){1'b0}}, t} + {{(CW-1){1'b0}}, 1'b1};
		lim_ext = {{(CW-16){1'b0}}, lim};
		return (t_next >= lim_ext) || (&t);
	endfunction

	assign tick_inc    = tick_q + {{(TW-1){1'b0}}, 1'b1};
	assign tick_at_max = &tick_q;
	assign shift_rd    = (tick_q == '0) ? {line_level, shift_q[7:1]} : shift_q;

	// outputs come from the state before this tick
	always_comb begin
		res.line_release   = 1'b1;
		res.busy_res       = 1'b1;
		res.done_res       = 1'b0;
		res.temp_low_byte  = low_q;
		res.temp_high_byte = high_q;
		unique case (phase_q)
			PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: res.line_release = 1'b0;
			PH_WR_BIT:                        res.line_release = shift_q[0];
			PH_DONE: begin
				res.busy_res = 1'b0;
				res.done_res = 1'b1;
			end
			PH_RST_WAIT, PH_POLL, PH_RD_BIT: ;
			default:                          res.busy_res = 1'b0;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		step_d  = step_q;
		shift_d = shift_q;
		low_d   = low_q;
		high_d  = high_q;
		go      = 1'b0;
		step_go = step_q + 4'd1;

		unique case (phase_q)
			PH_RST_LOW: begin
				if (timed_over(tick_q, cfg.reset_low_ticks)) begin
					tick_d  = '0;
					phase_d = PH_RST_WAIT;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_RST_WAIT: begin
				if (timed_over(tick_q, cfg.reset_wait_ticks)) begin
					go = 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_WR_LOW: begin
				tick_d  = '0;
				phase_d = PH_WR_BIT;
			end
			PH_WR_BIT: begin
				if (timed_over(tick_q, cfg.slot_ticks)) begin
					tick_d  = '0;
					shift_d = {1'b0, shift_q[7:1]};
					bit_d   = bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						go = 1'b1;
					end else begin
						phase_d = PH_WR_LOW;
					end
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_POLL: begin
				// wait while a conversion holds the line low, up to the poll limit
				if (!line_level && ({{(CW-TW){1'b0}}, tick_q} < {{(CW-16){1'b0}}, cfg.poll_limit})
						&& !tick_at_max) begin
					tick_d = tick_inc;
				end else begin
					go = 1'b1;
				end
			end
			PH_RD_LOW: begin
				if (timed_over(tick_q, cfg.read_low_ticks)) begin
					tick_d  = '0;
					phase_d = PH_RD_BIT;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_RD_BIT: begin
				shift_d = shift_rd;
				if (timed_over(tick_q, cfg.slot_ticks)) begin
					tick_d = '0;
					bit_d  = bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						if (step_q == ST_READ_LO) begin
							low_d = shift_rd;
						end else begin
							high_d = shift_rd;
						end
						go = 1'b1;
					end else begin
						phase_d = PH_RD_LOW;
					end
				end else begin
					tick_d = tick_inc;
				end
			end
			default: begin
				// idle, done and meaningless codes
				phase_d = PH_IDLE;
				if (start_request) begin
					go      = 1'b1;
					step_go = ST_RESET1;
				end
			end
		endcase

		if (go) begin
			step_d = step_go;
			tick_d = '0;
			bit_d  = '0;
			unique case (step_go)
				ST_RESET1, ST_RESET2: phase_d = PH_RST_LOW;
				ST_SKIP1, ST_SKIP2: begin
					shift_d = otr_pkg::CMD_SKIP_ROM;
					phase_d = PH_WR_LOW;
				end
				ST_CONVERT: begin
					shift_d = otr_pkg::CMD_CONVERT;
					phase_d = PH_WR_LOW;
				end
				ST_POLL: phase_d = PH_POLL;
				ST_READ_CMD: begin
					shift_d = otr_pkg::CMD_READ_SCRATCH;
					phase_d = PH_WR_LOW;
				end
				ST_READ_LO, ST_READ_HI: begin
					shift_d = 8'h00;
					phase_d = PH_RD_LOW;
				end
				default: phase_d = PH_DONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			step_q  <= '0;
			shift_q <= '0;
			low_q   <= '0;
			high_q  <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			step_q  <= step_d;
			shift_q <= shift_d;
			low_q   <= low_d;
			high_q  <= high_d;
		end
	end

endmodule

// ===== hw/rtl/onewire_temperature_read_master.sv =====
// a tick beat is registered in the input register, and its result then in the result register
// throughput: one tick beat per cycle unless m_tready back-pressures; the sequencer update is a single
//   combinational pass between the input register and the result register
// reset: arst_n asynchronous, active low; sequencer goes idle with zero bytes,
//   timing registers return to their defaults, both stream sides empty
module onewire_temperature_read_master #(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	// tick stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] start_request, [1] line_level, [7:2] zero

	// result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] line_release, [1] busy_res, [2] done_res,
	                               // [10:3] temp_low_byte, [18:11] temp_high_byte,
	                               // [23:19] zero

	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	otr_pkg::cfg_t    cfg;
	otr_pkg::result_t res;

	// input register
	logic valid_s1;
	logic start_s1;
	logic level_s1;

	// result register
	logic             valid_s2;
	otr_pkg::result_t res_s2;

	logic advance;

	// a tick moves into the result register whenever that register is empty
	// or drained in the same cycle, so the input side keeps taking beats
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// registers are always writable
	assign cfg_ready = 1'b1;

	otr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// bus sequencer, steps once for each tick that advances
	otr_seq #(
		.TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (advance),
		.start_request (start_s1),
		.line_level    (level_s1),
		.cfg           (cfg),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			start_s1 <= s_tdata[0];
			level_s1 <= s_tdata[1];
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, res_s2};

endmodule
